### sv/evrs_pkg.sv
package evrs_pkg;

  localparam int VALUE_W = 16;
  // Element count is 7 bits: holds any list length up to 64.
  localparam int CNT_W = 7;
  // Jobs in flight between the load side and the sort side (one per bank).
  localparam int JOBS = 2;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic   bank;
    count_t count;
  } job_t;

endpackage

### sv/evrs_if.sv
interface evrs_in_if import evrs_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source(output valid, output value, output last, input ready);
  modport sink(input valid, input value, input last, output ready);
endinterface

interface evrs_out_if import evrs_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value_out;
  logic   last_out;

  modport source(output valid, output value_out, output last_out, input ready);
  modport sink(input valid, input value_out, input last_out, output ready);
endinterface

### sv/evrs_ram.sv
module evrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/evrs_front.sv
module evrs_front import evrs_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  evrs_in_if.sink                      in_ch,
  input  logic                         done,
  output logic                         we,
  output logic [$clog2(MAX_ITEMS):0]   waddr,
  output value_t                       wdata,
  output logic                         push,
  output job_t                         job
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam count_t MAX_CNT = CNT_W'(MAX_ITEMS);
  localparam logic [1:0] JOBS_V = 2'(JOBS);

  count_t     count;
  logic       bank;
  logic [1:0] pending;
  logic       take;
  logic       room;
  count_t     count_inc;

  assign in_ch.ready = (pending != JOBS_V);
  assign take        = in_ch.valid && in_ch.ready;
  assign room        = (count < MAX_CNT);
  assign count_inc   = room ? count + count_t'(1) : count;

  assign we    = take && room;
  assign waddr = {bank, count[IDX_W-1:0]};
  assign wdata = in_ch.value;
  assign push  = take && in_ch.last;
  assign job   = '{bank: bank, count: count_inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      bank    <= 1'b0;
      pending <= '0;
    end else begin
      if (take) begin
        if (in_ch.last) begin
          count <= '0;
          bank  <= ~bank;
        end else begin
          count <= count_inc;
        end
      end
      pending <= pending + {1'b0, push} - {1'b0, done};
    end
  end

endmodule

### sv/evrs_job_queue.sv
module evrs_job_queue import evrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       slot [JOBS];
  logic       wp;
  logic       rp;
  logic [1:0] used;

  assign empty = (used == 2'd0);
  assign head  = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_job;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      used <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      used <= used + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### sv/evrs_sort_row.sv
module evrs_sort_row import evrs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   ins,
  input  value_t key,
  input  logic   pop,
  output value_t head
);

  // Each cell holds one value; valid cells form a sorted run from cell 0.
  value_t     cells [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] take;

  assign head = cells[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      take[i] = !vld[i] || (key < cells[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ins && take[i]) begin
        if (i == 0 || !take[(i == 0) ? 0 : i-1]) begin
          cells[i] <= key;
        end else begin
          cells[i] <= cells[(i == 0) ? 0 : i-1];
        end
      end else if (pop && i < DEPTH-1) begin
        cells[i] <= cells[(i < DEPTH-1) ? i+1 : i];
      end
    end
    if (rst) begin
      vld <= '0;
    end else if (ins) begin
      vld <= {vld[DEPTH-2:0], 1'b1};
    end else if (pop) begin
      vld <= {1'b0, vld[DEPTH-1:1]};
    end
  end

endmodule

### sv/evrs_back.sv
module evrs_back import evrs_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  job_t                       q_head,
  output logic                       q_pop,
  output logic [$clog2(MAX_ITEMS):0] raddr,
  input  value_t                     rdata,
  output logic                       done,
  evrs_out_if.source                 out_ch
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  typedef struct packed {
    value_t value;
    logic   last;
  } res_t;

  logic [1:0] state;
  count_t     idx;
  count_t     n;
  logic       bank;
  logic       p_sort;
  logic       p_emit;
  logic       p_last;
  logic       at_end;
  logic       issue;
  logic       out_pop;
  logic [2:0] occ;
  logic       even;
  value_t     head;

  res_t       fq [2];
  logic       fwp;
  logic       frp;
  logic [1:0] fcnt;

  assign at_end  = (idx == n - count_t'(1));
  assign raddr   = {bank, idx[IDX_W-1:0]};
  assign out_pop = out_ch.valid && out_ch.ready;
  assign occ     = {1'b0, fcnt} + {2'b0, p_emit};
  assign issue   = (state == ST_EMIT) && (occ <= 3'd1 + {2'b0, out_pop});
  assign q_pop   = (state == ST_IDLE) && !q_empty;
  assign done    = issue && at_end;
  assign even    = !rdata[0];

  assign out_ch.valid     = (fcnt != 2'd0);
  assign out_ch.value_out = fq[frp].value;
  assign out_ch.last_out  = fq[frp].last;

  evrs_sort_row #(.DEPTH(MAX_ITEMS)) u_row (
    .clk  (clk),
    .rst  (rst),
    .ins  (p_sort && even),
    .key  (rdata),
    .pop  (p_emit && even),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (p_emit) begin
      fq[fwp] <= '{value: even ? head : rdata, last: p_last};
    end
    if (q_pop) begin
      n    <= q_head.count;
      bank <= q_head.bank;
    end
    p_last <= at_end;
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      p_sort <= 1'b0;
      p_emit <= 1'b0;
      fwp    <= 1'b0;
      frp    <= 1'b0;
      fcnt   <= '0;
    end else begin
      p_sort <= (state == ST_SORT);
      p_emit <= issue;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (!q_empty) begin
            state <= ST_SORT;
          end
        end
        ST_SORT: begin
          if (at_end) begin
            idx   <= '0;
            state <= ST_EMIT;
          end else begin
            idx <= idx + count_t'(1);
          end
        end
        ST_EMIT: begin
          if (issue) begin
            if (at_end) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + count_t'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (p_emit) begin
        fwp <= ~fwp;
      end
      if (out_pop) begin
        frp <= ~frp;
      end
      fcnt <= fcnt + {1'b0, p_emit} - {1'b0, out_pop};
    end
  end

endmodule

### sv/even_value_radix_sort_top.sv
// After the request marked last is accepted, the finished list is queued as a job, the sort side
// takes the job, reads the list once to sort its even values and again to emit the results.
// One input request is taken per cycle while loading, unless both banks are still waiting on the
// sort side; the sort side makes n reads to sort and n reads to emit, where n is the list length.
// Reset (rst, synchronous, active high) clears counts, pointers and the sort row valid bits;
// the element store itself is not cleared and needs no clearing pass.
module even_value_radix_sort_top import evrs_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic       clk,
  input  logic       rst,
  evrs_in_if.sink    in_ch,
  evrs_out_if.source out_ch
);

  // The element store holds two banks, each MAX_ITEMS entries rounded up to
  // a power of two, and the bank bit is the top address bit. The load side
  // fills one bank while the sort side works through the other, so a new
  // list can stream in while the previous one is being sorted and emitted.
  localparam int ADDR_W = $clog2(MAX_ITEMS) + 1;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  value_t            wdata;
  logic [ADDR_W-1:0] raddr;
  value_t            rdata;

  // A finished list becomes a job (bank and length) in a short queue.
  logic push;
  job_t push_job;
  logic q_pop;
  logic q_empty;
  job_t q_head;

  // The sort side pulses done once it has issued the last read of a bank,
  // which hands that bank back to the load side.
  logic done;

  evrs_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .done  (done),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .push  (push),
    .job   (push_job)
  );

  evrs_ram #(.WIDTH(VALUE_W), .DEPTH(2 ** ADDR_W)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  evrs_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // The sort side reads the bank once to insert every even value into a
  // sorted row of cells, then reads it again in position order: odd values
  // pass through and each even position takes the smallest value left in
  // the row. A two-entry output buffer keeps emission at one per cycle while out_ch is ready.
  evrs_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .raddr   (raddr),
    .rdata   (rdata),
    .done    (done),
    .out_ch  (out_ch)
  );

endmodule
